### src/nmea_osd_sentence_parser_assert.svh
// assertion macros shared by the checker of the osd sentence parser
// no dependencies; include by bare file name
`ifndef NMEA_OSD_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_OSD_SENTENCE_PARSER_ASSERT_SVH

// clocked check, quiet while reset is held
`define NOSP_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also covers the reset cycles
`define NOSP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/nosp_pkg.sv
// shared types and constants of the osd sentence parser
// used by every module of the block; no dependencies
package nosp_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int PROD_W      = VALUE_BITS + 4;
    localparam int OUT_W       = 16;
    localparam int SDATA_W     = 8;
    localparam int MDATA_W     = 96;
    localparam int NUM_FIELDS  = 5;
    localparam int LET_FIELDS  = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
    localparam logic [6:0] CC_MAX  = 7'd127;
    localparam logic [6:0] HDR_LEN = 7'd6;

    // field positions in the sentence
    localparam logic [3:0] FLD_HEADER    = 4'd0;
    localparam logic [3:0] FLD_HEADING   = 4'd1;
    localparam logic [3:0] FLD_HDG_STAT  = 4'd2;
    localparam logic [3:0] FLD_COURSE    = 4'd3;
    localparam logic [3:0] FLD_CRS_REF   = 4'd4;
    localparam logic [3:0] FLD_SPEED     = 4'd5;
    localparam logic [3:0] FLD_SPD_REF   = 4'd6;
    localparam logic [3:0] FLD_SET       = 4'd7;
    localparam logic [3:0] FLD_DRIFT     = 4'd8;
    localparam logic [3:0] FLD_UNITS     = 4'd9;

    // status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_HEADER = 4'd1;
    localparam logic [3:0] ST_MAX        = 4'd10;

    // letter codes
    localparam logic       HS_VALID = 1'b1;
    localparam logic       HS_VOID  = 1'b0;
    localparam logic [2:0] REF_B = 3'd0;
    localparam logic [2:0] REF_M = 3'd1;
    localparam logic [2:0] REF_W = 3'd2;
    localparam logic [2:0] REF_R = 3'd3;
    localparam logic [2:0] REF_P = 3'd4;
    localparam logic [1:0] UNIT_K = 2'd0;
    localparam logic [1:0] UNIT_N = 2'd1;
    localparam logic [1:0] UNIT_S = 2'd2;

    // characters
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_O     = "O";
    localparam logic [7:0] CH_S     = "S";
    localparam logic [7:0] CH_D     = "D";
    localparam logic [7:0] CH_A     = "A";
    localparam logic [7:0] CH_V     = "V";
    localparam logic [7:0] CH_B     = "B";
    localparam logic [7:0] CH_M     = "M";
    localparam logic [7:0] CH_W     = "W";
    localparam logic [7:0] CH_R     = "R";
    localparam logic [7:0] CH_P     = "P";
    localparam logic [7:0] CH_K     = "K";
    localparam logic [7:0] CH_N     = "N";

    // one classified byte as it travels from front to back
    typedef struct packed {
        logic       eos;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_dot;
        logic       is_comma;
        logic       is_star;
        logic       is_o;
        logic       is_s;
        logic       is_d;
        logic       hs_ok;
        logic       hs_code;
        logic       ref_ok;
        logic [2:0] ref_code;
        logic       unit_ok;
        logic [1:0] unit_code;
    } class_t;

endpackage

### src/nosp_queue.sv
// short fifo of classified words between front and back
// depends on nosp_pkg
module nosp_queue
    import nosp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  class_t push_word,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output class_t head_word
);

    class_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];

endmodule

### src/nosp_front.sv
// input side: takes sentence bytes and classifies each one
// depends on nosp_pkg; feeds nosp_queue
module nosp_front
    import nosp_pkg::*;
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDATA_W-1:0] s_tdata,   // char_in [7:0]
    input  logic               s_tlast,   // end_of_sentence
    input  logic               q_full,
    output logic               push,
    output class_t             push_word
);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // byte classification
    always_comb begin
        push_word           = '0;
        push_word.eos       = s_tlast;
        push_word.is_digit  = (s_tdata >= CH_0) && (s_tdata <= CH_9);
        push_word.digit     = 4'(s_tdata - CH_0);
        push_word.is_dot    = (s_tdata == CH_DOT);
        push_word.is_comma  = (s_tdata == CH_COMMA);
        push_word.is_star   = (s_tdata == CH_STAR);
        push_word.is_o      = (s_tdata == CH_O);
        push_word.is_s      = (s_tdata == CH_S);
        push_word.is_d      = (s_tdata == CH_D);
        push_word.hs_ok     = (s_tdata == CH_A) || (s_tdata == CH_V);
        push_word.hs_code   = (s_tdata == CH_A) ? HS_VALID : HS_VOID;
        push_word.ref_ok    = 1'b1;
        case (s_tdata)
            CH_B:    push_word.ref_code = REF_B;
            CH_M:    push_word.ref_code = REF_M;
            CH_W:    push_word.ref_code = REF_W;
            CH_R:    push_word.ref_code = REF_R;
            CH_P:    push_word.ref_code = REF_P;
            default: begin
                push_word.ref_code = REF_B;
                push_word.ref_ok   = 1'b0;
            end
        endcase
        push_word.unit_ok   = 1'b1;
        case (s_tdata)
            CH_K:    push_word.unit_code = UNIT_K;
            CH_N:    push_word.unit_code = UNIT_N;
            CH_S:    push_word.unit_code = UNIT_S;
            default: begin
                push_word.unit_code = UNIT_K;
                push_word.unit_ok   = 1'b0;
            end
        endcase
    end

endmodule

### src/nosp_back.sv
// back side: field parser, value stores and result register
// depends on nosp_pkg; drains nosp_queue
module nosp_back
    import nosp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  class_t             head_word,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata   // status[3:0] heading[19:4] heading_ok[20]
                                         // course[36:21] course_ref[39:37] speed[55:40]
                                         // speed_ref[58:56] set_value[74:59]
                                         // drift[90:75] units[92:91]
);

    logic [3:0]            field_index_reg, field_index_next;
    logic [6:0]            char_count_reg, char_count_next;
    logic [VALUE_BITS-1:0] accum_reg, accum_next;
    logic                  seen_dot_reg, seen_dot_next;
    logic                  seen_digit_reg, seen_digit_next;
    logic                  field_bad_reg, field_bad_next;
    logic [2:0]            letter_code_reg, letter_code_next;
    logic [3:0]            error_code_reg, error_code_next;
    logic                  finished_reg, finished_next;
    logic [OUT_W-1:0]      num_reg [NUM_FIELDS];
    logic [OUT_W-1:0]      num_next [NUM_FIELDS];
    logic [2:0]            let_reg [LET_FIELDS];
    logic [2:0]            let_next [LET_FIELDS];
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [MDATA_W-1:0]    m_tdata_reg, m_tdata_next;

    function automatic logic is_numeric(input logic [3:0] fi);
        case (fi)
            FLD_HEADING, FLD_COURSE, FLD_SPEED, FLD_SET, FLD_DRIFT: is_numeric = 1'b1;
            default: is_numeric = 1'b0;
        endcase
    endfunction

    function automatic logic [2:0] num_slot(input logic [3:0] fi);
        case (fi)
            FLD_HEADING: num_slot = 3'd0;
            FLD_COURSE:  num_slot = 3'd1;
            FLD_SPEED:   num_slot = 3'd2;
            FLD_SET:     num_slot = 3'd3;
            default:     num_slot = 3'd4;
        endcase
    endfunction

    function automatic logic [1:0] let_slot(input logic [3:0] fi);
        case (fi)
            FLD_HDG_STAT: let_slot = 2'd0;
            FLD_CRS_REF:  let_slot = 2'd1;
            FLD_SPD_REF:  let_slot = 2'd2;
            default:      let_slot = 2'd3;
        endcase
    endfunction

    // does the open field pass its check when closed
    function automatic logic field_pass(input logic [3:0] fi, input logic [6:0] cc,
                                        input logic bad, input logic dig);
        if (fi == FLD_HEADER) begin
            field_pass = !bad && (cc == HDR_LEN);
        end else if (is_numeric(fi)) begin
            field_pass = !bad && dig;
        end else begin
            field_pass = !bad && (cc == 7'd1);
        end
    endfunction

    // a final byte is taken only when the output register is free or being read
    assign pop = head_valid && (!head_word.eos || !m_tvalid_reg || m_tready);

    // parser step for one word
    always_comb begin
        logic [6:0]        pos;
        logic [PROD_W-1:0] prod;
        logic              delim;
        logic              lok;
        logic [2:0]        lval;

        field_index_next = field_index_reg;
        char_count_next  = char_count_reg;
        accum_next       = accum_reg;
        seen_dot_next    = seen_dot_reg;
        seen_digit_next  = seen_digit_reg;
        field_bad_next   = field_bad_reg;
        letter_code_next = letter_code_reg;
        error_code_next  = error_code_reg;
        finished_next    = finished_reg;
        num_next         = num_reg;
        let_next         = let_reg;
        m_tdata_next     = m_tdata_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        pos              = char_count_reg;
        prod             = '0;
        lok              = 1'b0;
        lval             = 3'd0;
        delim            = (field_index_reg == FLD_UNITS) ? head_word.is_star
                                                          : head_word.is_comma;

        if (pop) begin
            if (error_code_reg == ST_OK && !finished_reg) begin
                if (delim) begin
                    // close the current field
                    if (field_pass(field_index_next, char_count_next, field_bad_next,
                                   seen_digit_next)) begin
                        if (field_index_next == FLD_HEADER) begin
                        end else if (is_numeric(field_index_next)) begin
                            num_next[num_slot(field_index_next)] = OUT_W'(accum_next);
                        end else begin
                            let_next[let_slot(field_index_next)] = letter_code_next;
                        end
                        if (field_index_next == FLD_UNITS) begin
                            finished_next = 1'b1;
                        end else begin
                            field_index_next = field_index_next + 4'd1;
                            char_count_next  = '0;
                            accum_next       = '0;
                            seen_dot_next    = 1'b0;
                            seen_digit_next  = 1'b0;
                            field_bad_next   = 1'b0;
                            letter_code_next = 3'd0;
                        end
                    end else begin
                        error_code_next = field_index_next + 4'd1;
                    end
                end else begin
                    // feed one character into the open field
                    if (char_count_reg != CC_MAX) begin
                        char_count_next = char_count_reg + 7'd1;
                    end
                    if (field_index_reg == FLD_HEADER) begin
                        if ((pos == 7'd3 && !head_word.is_o) ||
                            (pos == 7'd4 && !head_word.is_s) ||
                            (pos == 7'd5 && !head_word.is_d) ||
                            (pos >= HDR_LEN)) begin
                            field_bad_next = 1'b1;
                        end
                    end else if (is_numeric(field_index_reg)) begin
                        if (head_word.is_digit) begin
                            if (pos == 7'd0 || (pos == 7'd1 && seen_dot_reg)) begin
                                seen_digit_next = 1'b1;
                            end
                            if (!seen_dot_reg) begin
                                prod = (PROD_W'(accum_reg) << 3) + (PROD_W'(accum_reg) << 1)
                                     + PROD_W'(head_word.digit);
                                accum_next = (prod > PROD_W'(VALUE_MAX)) ? VALUE_MAX
                                                                         : prod[VALUE_BITS-1:0];
                            end
                        end else if (head_word.is_dot) begin
                            seen_dot_next = 1'b1;
                        end else begin
                            field_bad_next = 1'b1;
                        end
                    end else begin
                        case (field_index_reg)
                            FLD_HDG_STAT: begin
                                lok  = head_word.hs_ok;
                                lval = {2'b00, head_word.hs_code};
                            end
                            FLD_CRS_REF, FLD_SPD_REF: begin
                                lok  = head_word.ref_ok;
                                lval = head_word.ref_code;
                            end
                            default: begin
                                lok  = head_word.unit_ok;
                                lval = {1'b0, head_word.unit_code};
                            end
                        endcase
                        if (pos != 7'd0 || !lok) begin
                            field_bad_next = 1'b1;
                        end else begin
                            letter_code_next = lval;
                        end
                    end
                end
                // sentence ends inside a field
                if (head_word.eos && error_code_next == ST_OK && !finished_next) begin
                    if (field_pass(field_index_next, char_count_next, field_bad_next,
                                   seen_digit_next)) begin
                        if (field_index_next == FLD_HEADER) begin
                        end else if (is_numeric(field_index_next)) begin
                            num_next[num_slot(field_index_next)] = OUT_W'(accum_next);
                        end else begin
                            let_next[let_slot(field_index_next)] = letter_code_next;
                        end
                        if (field_index_next == FLD_UNITS) begin
                            finished_next = 1'b1;
                        end else begin
                            error_code_next = field_index_next + 4'd2;
                        end
                    end else begin
                        error_code_next = field_index_next + 4'd1;
                    end
                end
            end
            // emit result and return to the header state
            if (head_word.eos) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {3'b000, let_next[3][1:0], num_next[4], num_next[3],
                                 let_next[2], num_next[2], let_next[1], num_next[1],
                                 let_next[0][0], num_next[0], error_code_next};
                field_index_next = FLD_HEADER;
                char_count_next  = '0;
                accum_next       = '0;
                seen_dot_next    = 1'b0;
                seen_digit_next  = 1'b0;
                field_bad_next   = 1'b0;
                letter_code_next = 3'd0;
                error_code_next  = ST_OK;
                finished_next    = 1'b0;
                for (int i = 0; i < NUM_FIELDS; i++) begin
                    num_next[i] = '0;
                end
                for (int i = 0; i < LET_FIELDS; i++) begin
                    let_next[i] = '0;
                end
            end
        end
    end

    // parser state and stores
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_index_reg <= FLD_HEADER;
            char_count_reg  <= '0;
            accum_reg       <= '0;
            seen_dot_reg    <= 1'b0;
            seen_digit_reg  <= 1'b0;
            field_bad_reg   <= 1'b0;
            letter_code_reg <= 3'd0;
            error_code_reg  <= ST_OK;
            finished_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                num_reg[i] <= '0;
            end
            for (int i = 0; i < LET_FIELDS; i++) begin
                let_reg[i] <= '0;
            end
        end else begin
            field_index_reg <= field_index_next;
            char_count_reg  <= char_count_next;
            accum_reg       <= accum_next;
            seen_dot_reg    <= seen_dot_next;
            seen_digit_reg  <= seen_digit_next;
            field_bad_reg   <= field_bad_next;
            letter_code_reg <= letter_code_next;
            error_code_reg  <= error_code_next;
            finished_reg    <= finished_next;
            m_tvalid_reg    <= m_tvalid_next;
            num_reg         <= num_next;
            let_reg         <= let_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### src/nmea_osd_sentence_parser.sv
// top level of the osd sentence parser: front, queue and back
// depends on nosp_pkg, nosp_front, nosp_queue, nosp_back
//
// Input stream s_*: one sentence byte per word in s_tdata, s_tlast high on
// the final byte of a sentence. Output stream m_*: one result word per
// sentence, carrying the status code and the decoded fields.
// Bytes are accepted back to back, one per clock, as long as the
// two-entry queue between classifier and parser has room. The parser drains
// the queue at one word per cycle, except that a final byte waits while
// the output register holds a result not yet taken. The final byte passes
// through the queue and then the parser's output register to m_tvalid.
// When the receiver stalls, the result waits in the output register and
// bytes of the next sentence keep being parsed; only its final byte waits
// at the queue head, and once the queue fills s_tready drops.
// Reset (aresetn low, synchronous) empties the queue, returns the parser to
// the header field with all stores at zero and clears m_tvalid.
module nmea_osd_sentence_parser
    import nosp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SDATA_W-1:0] s_tdata,   // char_in [7:0]
    input  logic               s_tlast,   // end_of_sentence
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata    // status[3:0] heading[19:4] heading_ok[20]
                                          // course[36:21] course_ref[39:37] speed[55:40]
                                          // speed_ref[58:56] set_value[74:59]
                                          // drift[90:75] units[92:91]
);

    logic   q_full;
    logic   push;
    class_t push_word;
    logic   pop;
    logic   head_valid;
    class_t head_word;

    // classify incoming bytes
    nosp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    // decouple classifier from parser
    nosp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_word  (push_word),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // parse fields and hold the result
    nosp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_word  (head_word),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### src/nosp_checker.sv
// port-level checks of the osd sentence parser, bound to the top level
// depends on nosp_pkg and nmea_osd_sentence_parser_assert.svh
`include "nmea_osd_sentence_parser_assert.svh"

module nosp_checker
    import nosp_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [SDATA_W-1:0] s_tdata,
    input logic               s_tlast,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [MDATA_W-1:0] m_tdata
);

    // a stalled result word holds
    `NOSP_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // no result right after reset
    `NOSP_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_tvalid, "result valid after reset")

    // bad header leaves every field at zero
    `NOSP_ASSERT_CLK(a_bad_hdr_zero, m_tvalid && (m_tdata[3:0] == ST_BAD_HEADER) |-> (m_tdata[92:4] == '0), "fields set on bad header")

    // status in range, and a clean sentence carries legal letter codes
    `NOSP_ASSERT_CLK(a_status_range, m_tvalid |-> (m_tdata[3:0] <= ST_MAX) && ((m_tdata[3:0] != ST_OK) || ((m_tdata[92:91] != 2'd3) && (m_tdata[39:37] <= REF_P) && (m_tdata[58:56] <= REF_P))), "bad status or letter code")

endmodule

bind nmea_osd_sentence_parser nosp_checker u_nosp_checker (.*);
